// File: src/pcse_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pcse_pkg
// Shared types and constants of the PIM command step expander.
// ---------------------------------------------------------------------------
package pcse_pkg;

    // Width of a loop count held in a configuration register.
    localparam int CNT_W = 3;
    // Channel selection vector: one bit for every channel index a count can reach.
    localparam int CHAN_SEL_W = 2 ** CNT_W;
    localparam int CHAN_IDX_W = CNT_W;
    // Width of the emitted-step counter (at most 64 steps per command).
    localparam int STEP_CNT_W = 6;
    localparam logic [STEP_CNT_W-1:0] STEP_CAP_LAST = '1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_BANKS    = 2'd1;
    localparam logic [1:0] CFG_LANES    = 2'd2;

    // Command opcodes.
    localparam logic [3:0] KIND_WR_GB   = 4'd0;
    localparam logic [3:0] KIND_WR_BIAS = 4'd1;
    localparam logic [3:0] KIND_MAC_ABK = 4'd2;
    localparam logic [3:0] KIND_MAC_SBK = 4'd3;
    localparam logic [3:0] KIND_RD_MAC  = 4'd4;
    localparam logic [3:0] KIND_WR_SBK  = 4'd5;
    localparam logic [3:0] KIND_RD_SBK  = 4'd6;

    // Micro-step kinds.
    typedef enum logic [2:0] {
        STEP_WR_GLOBAL_LANE = 3'd0,
        STEP_WR_BIAS_BANK   = 3'd1,
        STEP_MAC_LANE       = 3'd2,
        STEP_RD_MAC_BANK    = 3'd3,
        STEP_WR_SBK_LANE    = 3'd4,
        STEP_RD_SBK_LANE    = 3'd5
    } step_kind_t;

    // One classified command, as queued between the front and the back.
    typedef struct packed {
        step_kind_t              skind;
        logic [CHAN_SEL_W-1:0]   chan_sel;
        logic [CNT_W-1:0]        bank_n;
        logic [CNT_W-1:0]        lane_n;
        logic                    fixed_bank;
        logic [1:0]              bank;
        logic [13:0]             row;
        logic [6:0]              col;
        logic [8:0]              reg_val;
    } cmd_t;

endpackage : pcse_pkg
`default_nettype wire

// File: src/pcse_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pcse_front
// Accepts commands, resolves the channel set and loop bounds, and drops
// commands that expand into no steps.
// ---------------------------------------------------------------------------
module pcse_front
    import pcse_pkg::*;
#(
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_BANKS    = 4,
    parameter int MAX_LANES    = 4
) (
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [3:0]        s_kind,
    input  wire logic signed [2:0] s_forced_channel,
    input  wire logic              s_all_channels,
    input  wire logic [3:0]        s_channel_mask,
    input  wire logic signed [2:0] s_bank_field,
    input  wire logic signed [14:0] s_row_field,
    input  wire logic signed [7:0] s_col_field,
    input  wire logic signed [8:0] s_reg_field,
    input  wire logic [CNT_W-1:0]  channels_in_use,
    input  wire logic [CNT_W-1:0]  banks_in_use,
    input  wire logic [CNT_W-1:0]  lanes_in_use,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output cmd_t                   push_cmd
);

    localparam logic [4:0] MAX_CH_W = 5'(MAX_CHANNELS);
    localparam logic [4:0] MAX_BK_W = 5'(MAX_BANKS);
    localparam logic [4:0] MAX_LN_W = 5'(MAX_LANES);

    logic [CNT_W-1:0]      nch;
    logic [CNT_W-1:0]      nbk;
    logic [CNT_W-1:0]      nln;
    logic [CHAN_SEL_W-1:0] mask_sel;
    logic [8:0]            reg_nn;
    logic [6:0]            col_nn;
    logic                  is_op;
    logic                  uses_banks;
    logic                  uses_lanes;
    logic                  empty;

    // Loop counts saturate at the parameterised maxima.
    assign nch = ({2'b00, channels_in_use} > MAX_CH_W) ? MAX_CH_W[CNT_W-1:0] : channels_in_use;
    assign nbk = ({2'b00, banks_in_use} > MAX_BK_W) ? MAX_BK_W[CNT_W-1:0] : banks_in_use;
    assign nln = ({2'b00, lanes_in_use} > MAX_LN_W) ? MAX_LN_W[CNT_W-1:0] : lanes_in_use;

    // Negative fields count as zero.
    assign reg_nn = s_reg_field[8] ? 9'd0 : {1'b0, s_reg_field[7:0]};
    assign col_nn = s_col_field[7] ? 7'd0 : s_col_field[6:0];

    // Channels below the count that the mask or the all flag selects.
    always_comb begin
        for (int i = 0; i < CHAN_SEL_W; i++) begin
            mask_sel[i] = (CNT_W'(i) < nch) &&
                          (s_all_channels || ((i < 4) && s_channel_mask[i % 4]));
        end
    end

    // Opcode decode into step kind and loop shape, plus the channel set.
    always_comb begin
        is_op                = 1'b1;
        uses_banks           = 1'b0;
        uses_lanes           = 1'b0;
        push_cmd.skind       = STEP_WR_GLOBAL_LANE;
        push_cmd.fixed_bank  = 1'b0;
        push_cmd.reg_val     = reg_nn;
        unique case (s_kind)
            KIND_WR_GB: begin
                uses_lanes       = 1'b1;
                push_cmd.reg_val = reg_nn + 9'(col_nn);
            end
            KIND_WR_BIAS: begin
                push_cmd.skind = STEP_WR_BIAS_BANK;
                uses_banks     = 1'b1;
            end
            KIND_MAC_ABK: begin
                push_cmd.skind = STEP_MAC_LANE;
                uses_banks     = 1'b1;
                uses_lanes     = 1'b1;
            end
            KIND_MAC_SBK: begin
                push_cmd.skind      = STEP_MAC_LANE;
                uses_lanes          = 1'b1;
                push_cmd.fixed_bank = 1'b1;
            end
            KIND_RD_MAC: begin
                push_cmd.skind = STEP_RD_MAC_BANK;
                uses_banks     = 1'b1;
            end
            KIND_WR_SBK: begin
                push_cmd.skind      = STEP_WR_SBK_LANE;
                uses_lanes          = 1'b1;
                push_cmd.fixed_bank = 1'b1;
                push_cmd.reg_val    = reg_nn + 9'(col_nn);
            end
            KIND_RD_SBK: begin
                push_cmd.skind      = STEP_RD_SBK_LANE;
                uses_lanes          = 1'b1;
                push_cmd.fixed_bank = 1'b1;
                push_cmd.reg_val    = reg_nn + 9'(col_nn);
            end
            default: begin
                is_op = 1'b0;
            end
        endcase

        // Channel set: forced channel, else the mask selection, else channel zero.
        push_cmd.chan_sel = '0;
        if (!s_forced_channel[2]) begin
            push_cmd.chan_sel[s_forced_channel[1:0]] = 1'b1;
        end else if (mask_sel == '0) begin
            push_cmd.chan_sel[0] = 1'b1;
        end else begin
            push_cmd.chan_sel = mask_sel;
        end

        push_cmd.bank_n = uses_banks ? nbk : CNT_W'(1);
        push_cmd.lane_n = uses_lanes ? nln : CNT_W'(1);
        push_cmd.bank   = s_bank_field[2] ? 2'd0 : s_bank_field[1:0];
        push_cmd.row    = s_row_field[14] ? 14'd0 : s_row_field[13:0];
        push_cmd.col    = col_nn;
    end

    // No-op opcodes and zero bank or lane counts are consumed without a queue entry.
    assign empty      = !is_op || (push_cmd.bank_n == '0) || (push_cmd.lane_n == '0);
    assign s_ready    = push_ready;
    assign push_valid = s_valid && !empty;

endmodule : pcse_front
`default_nettype wire

// File: src/pcse_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pcse_queue
// Two-entry command queue that decouples the front from the back.
// ---------------------------------------------------------------------------
module pcse_queue
    import pcse_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop,
    output cmd_t      pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule : pcse_queue
`default_nettype wire

// File: src/pcse_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pcse_back
// Step sequencer: walks channels, banks and lanes of the head command and
// drives one micro-step per cycle into the output register unless m_ready stalls it.
// ---------------------------------------------------------------------------
module pcse_back
    import pcse_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   cmd_valid,
    input  wire cmd_t   cmd,
    output logic        cmd_pop,
    output logic        m_valid,
    input  wire logic   m_ready,
    output logic [2:0]  m_step_kind,
    output logic [1:0]  m_step_channel,
    output logic [1:0]  m_step_bank,
    output logic [13:0] m_step_row,
    output logic [6:0]  m_step_col,
    output logic [1:0]  m_step_lane,
    output logic [8:0]  m_step_reg,
    output logic        m_last_step
);

    logic [CNT_W-1:0]      bank_reg;
    logic [CNT_W-1:0]      bank_next;
    logic [CNT_W-1:0]      lane_reg;
    logic [CNT_W-1:0]      lane_next;
    logic [CHAN_SEL_W-1:0] done_reg;
    logic [CHAN_SEL_W-1:0] done_next;
    logic [STEP_CNT_W-1:0] count_reg;
    logic [STEP_CNT_W-1:0] count_next;
    logic                  valid_reg;
    logic                  valid_next;

    logic [2:0]  kind_reg;
    logic [1:0]  chan_reg;
    logic [1:0]  bank_out_reg;
    logic [13:0] row_reg;
    logic [6:0]  col_reg;
    logic [1:0]  lane_out_reg;
    logic [8:0]  reg_out_reg;
    logic        last_reg;

    logic [CHAN_SEL_W-1:0] rem;
    logic [CHAN_SEL_W-1:0] low_bit;
    logic [CHAN_IDX_W-1:0] cur_chan;
    logic                  more_chan;
    logic                  end_lane;
    logic                  end_bank;
    logic                  last;
    logic                  fire;

    // Remaining channels and the lowest one of them.
    assign rem = cmd.chan_sel & ~done_reg;
    always_comb begin
        cur_chan = '0;
        for (int i = CHAN_SEL_W - 1; i >= 0; i--) begin
            if (rem[i]) begin
                cur_chan = CHAN_IDX_W'(i);
            end
        end
    end
    assign low_bit   = CHAN_SEL_W'(1) << cur_chan;
    assign more_chan = |(rem & ~low_bit);

    // Loop end detection and the step cap.
    assign end_lane = (lane_reg == cmd.lane_n - CNT_W'(1));
    assign end_bank = (bank_reg == cmd.bank_n - CNT_W'(1));
    assign last     = (end_lane && end_bank && !more_chan) || (count_reg == STEP_CAP_LAST);
    assign fire     = cmd_valid && (!valid_reg || m_ready);
    assign cmd_pop  = fire && last;

    // Loop counter update.
    always_comb begin
        bank_next  = bank_reg;
        lane_next  = lane_reg;
        done_next  = done_reg;
        count_next = count_reg;
        if (fire) begin
            if (last) begin
                bank_next  = '0;
                lane_next  = '0;
                done_next  = '0;
                count_next = '0;
            end else begin
                count_next = count_reg + STEP_CNT_W'(1);
                if (end_lane) begin
                    lane_next = '0;
                    if (end_bank) begin
                        bank_next = '0;
                        done_next = done_reg | low_bit;
                    end else begin
                        bank_next = bank_reg + CNT_W'(1);
                    end
                end else begin
                    lane_next = lane_reg + CNT_W'(1);
                end
            end
        end
    end

    // Output register valid.
    always_comb begin
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg  <= '0;
            lane_reg  <= '0;
            done_reg  <= '0;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            bank_reg  <= bank_next;
            lane_reg  <= lane_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (fire) begin
            kind_reg     <= cmd.skind;
            chan_reg     <= cur_chan[1:0];
            bank_out_reg <= cmd.fixed_bank ? cmd.bank : bank_reg[1:0];
            row_reg      <= cmd.row;
            col_reg      <= cmd.col;
            lane_out_reg <= lane_reg[1:0];
            reg_out_reg  <= cmd.reg_val;
            last_reg     <= last;
        end
    end

    assign m_valid        = valid_reg;
    assign m_step_kind    = kind_reg;
    assign m_step_channel = chan_reg;
    assign m_step_bank    = bank_out_reg;
    assign m_step_row     = row_reg;
    assign m_step_col     = col_reg;
    assign m_step_lane    = lane_out_reg;
    assign m_step_reg     = reg_out_reg;
    assign m_last_step    = last_reg;

endmodule : pcse_back
`default_nettype wire

// File: src/pim_command_step_expander.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pim_command_step_expander
// Expands processing-in-memory commands into per-channel, per-bank and
// per-lane micro-steps.
// ---------------------------------------------------------------------------
// A command is accepted when the two-entry queue has room, and the back-end
// sequencer then emits one micro-step per cycle while m_ready does not stall
// the output: a command has as many steps as selected channels times banks
// times lanes, at most 64, so the step sequencer sets the rate. Commands that
// expand into no steps (unknown opcodes, zero bank or lane counts) are taken
// when the queue has room and produce nothing. The final step of each command
// carries last_step. Configuration writes are always accepted and take effect
// on the next command.
module pim_command_step_expander
    import pcse_pkg::*;
#(
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_BANKS    = 4,
    parameter int MAX_LANES    = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CNT_W-1:0]   cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [3:0]         s_kind,
    input  wire logic signed [2:0]  s_forced_channel,
    input  wire logic               s_all_channels,
    input  wire logic [3:0]         s_channel_mask,
    input  wire logic signed [2:0]  s_bank_field,
    input  wire logic signed [14:0] s_row_field,
    input  wire logic signed [7:0]  s_col_field,
    input  wire logic signed [8:0]  s_reg_field,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_step_kind,
    output logic [1:0]              m_step_channel,
    output logic [1:0]              m_step_bank,
    output logic [13:0]             m_step_row,
    output logic [6:0]              m_step_col,
    output logic [1:0]              m_step_lane,
    output logic [8:0]              m_step_reg,
    output logic                    m_last_step
);

    logic [CNT_W-1:0] channels_reg;
    logic [CNT_W-1:0] banks_reg;
    logic [CNT_W-1:0] lanes_reg;
    logic             cfg_we;
    logic             push_valid;
    logic             push_ready;
    cmd_t             push_cmd;
    logic             pop_valid;
    logic             pop;
    cmd_t             pop_cmd;

    // Configuration registers; writes beyond the register list are ignored.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channels_reg <= CNT_W'(4);
            banks_reg    <= CNT_W'(4);
            lanes_reg    <= CNT_W'(4);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CHANNELS: channels_reg <= cfg_data;
                CFG_BANKS:    banks_reg    <= cfg_data;
                CFG_LANES:    lanes_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Front end: command classification.
    pcse_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_BANKS    (MAX_BANKS),
        .MAX_LANES    (MAX_LANES)
    ) u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_forced_channel (s_forced_channel),
        .s_all_channels   (s_all_channels),
        .s_channel_mask   (s_channel_mask),
        .s_bank_field     (s_bank_field),
        .s_row_field      (s_row_field),
        .s_col_field      (s_col_field),
        .s_reg_field      (s_reg_field),
        .channels_in_use  (channels_reg),
        .banks_in_use     (banks_reg),
        .lanes_in_use     (lanes_reg),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_cmd         (push_cmd)
    );

    // Command queue between front and back.
    pcse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    // Back end: step sequencer and output register.
    pcse_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (pop_valid),
        .cmd            (pop_cmd),
        .cmd_pop        (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_step_kind    (m_step_kind),
        .m_step_channel (m_step_channel),
        .m_step_bank    (m_step_bank),
        .m_step_row     (m_step_row),
        .m_step_col     (m_step_col),
        .m_step_lane    (m_step_lane),
        .m_step_reg     (m_step_reg),
        .m_last_step    (m_last_step)
    );

endmodule : pim_command_step_expander
`default_nettype wire
